// ===== rtl/midpoint_ellipse_rasterizer_macros.svh =====
// Assertion macros used by the checker module.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mer_pkg.sv =====
// Types, codes and microcode program of the ellipse rasterizer.
package mer_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] mer_pc_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_SX_RY,
        MUL_PR_RY,
        MUL_P_X1,
        MUL_TMP_Y1
    } mer_mul_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SX,
        WR_SY,
        WR_Q,
        WR_SXSY
    } mer_wr_sel_t;

    typedef enum logic [2:0] {
        DEC_HOLD,
        DEC_INIT,
        DEC_STEP,
        DEC_SW_A,
        DEC_SW_B
    } mer_dec_op_t;

    typedef enum logic [1:0] {
        NXT_INC,
        NXT_END,
        NXT_STEP,
        NXT_LOOP
    } mer_nxt_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } mer_seq_state_t;

    typedef struct packed {
        mer_mul_sel_t mul_sel;
        mer_wr_sel_t  wr_sel;
        mer_dec_op_t  dec_op;
        logic         tmp_ld;
        logic         set_r2;
        logic         emit;
        mer_nxt_t     nxt;
    } mer_cw_t;

    typedef struct packed {
        logic take_sw;
        logic last;
        logic hold;
    } mer_flags_t;

    localparam mer_pc_t PC_ST0 = 4'd0;
    localparam mer_pc_t PC_ST1 = 4'd1;
    localparam mer_pc_t PC_ST2 = 4'd2;
    localparam mer_pc_t PC_ST3 = 4'd3;
    localparam mer_pc_t PC_ST4 = 4'd4;
    localparam mer_pc_t PC_SP0 = 4'd5;
    localparam mer_pc_t PC_SP1 = 4'd6;
    localparam mer_pc_t PC_SW0 = 4'd7;
    localparam mer_pc_t PC_SW1 = 4'd8;
    localparam mer_pc_t PC_SW2 = 4'd9;

    localparam mer_cw_t CW_NOP = '{
        mul_sel: MUL_NONE,
        wr_sel:  WR_NONE,
        dec_op:  DEC_HOLD,
        tmp_ld:  1'b0,
        set_r2:  1'b0,
        emit:    1'b0,
        nxt:     NXT_END
    };

    // start: squares, rx^2*ry, rx^2*ry^2, region-1 decision
    // step: emit and advance, then decision update
    // switch: 4*P*(x+1) + ry^2 + 4*(Q-rx^2)*(y-1) - 4*rx^2*ry^2
    function automatic mer_cw_t mer_ucode(input mer_pc_t pc);
        mer_cw_t cw;
        cw = CW_NOP;
        case (pc)
            PC_ST0: begin
                cw.mul_sel = MUL_RX_RX;
                cw.nxt     = NXT_INC;
            end
            PC_ST1: begin
                cw.wr_sel  = WR_SX;
                cw.mul_sel = MUL_RY_RY;
                cw.nxt     = NXT_INC;
            end
            PC_ST2: begin
                cw.wr_sel  = WR_SY;
                cw.mul_sel = MUL_SX_RY;
                cw.nxt     = NXT_INC;
            end
            PC_ST3: begin
                cw.wr_sel  = WR_Q;
                cw.mul_sel = MUL_PR_RY;
                cw.nxt     = NXT_INC;
            end
            PC_ST4: begin
                cw.wr_sel = WR_SXSY;
                cw.dec_op = DEC_INIT;
                cw.nxt    = NXT_END;
            end
            PC_SP0: begin
                cw.emit = 1'b1;
                cw.nxt  = NXT_STEP;
            end
            PC_SP1: begin
                cw.dec_op = DEC_STEP;
                cw.nxt    = NXT_END;
            end
            PC_SW0: begin
                cw.mul_sel = MUL_P_X1;
                cw.tmp_ld  = 1'b1;
                cw.set_r2  = 1'b1;
                cw.nxt     = NXT_INC;
            end
            PC_SW1: begin
                cw.mul_sel = MUL_TMP_Y1;
                cw.dec_op  = DEC_SW_A;
                cw.nxt     = NXT_INC;
            end
            PC_SW2: begin
                cw.dec_op = DEC_SW_B;
                cw.nxt    = NXT_LOOP;
            end
            default: cw = CW_NOP;
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/mer_seq.sv =====
// Microcode sequencer: step counter, program ROM and jump logic.
module mer_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                launch,
    input  mer_pkg::mer_pc_t    launch_pc,
    input  mer_pkg::mer_flags_t flags,
    output mer_pkg::mer_cw_t    cw,
    output logic                busy
);

    mer_pkg::mer_seq_state_t state_reg, state_next;
    mer_pkg::mer_pc_t        pc_reg, pc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mer_pkg::SEQ_IDLE;
            pc_reg    <= mer_pkg::PC_ST0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cw         = mer_pkg::CW_NOP;
        case (state_reg)
            mer_pkg::SEQ_IDLE: begin
                if (launch) begin
                    state_next = mer_pkg::SEQ_RUN;
                    pc_next    = launch_pc;
                end
            end
            mer_pkg::SEQ_RUN: begin
                cw = mer_pkg::mer_ucode(pc_reg);
                if (!flags.hold) begin
                    case (cw.nxt)
                        mer_pkg::NXT_INC: pc_next = pc_reg + mer_pkg::mer_pc_t'(1);
                        mer_pkg::NXT_END: state_next = mer_pkg::SEQ_IDLE;
                        mer_pkg::NXT_STEP: begin
                            if (flags.take_sw) begin
                                pc_next = mer_pkg::PC_SW0;
                            end else if (flags.last) begin
                                state_next = mer_pkg::SEQ_IDLE;
                            end else begin
                                pc_next = pc_reg + mer_pkg::mer_pc_t'(1);
                            end
                        end
                        mer_pkg::NXT_LOOP: pc_next = mer_pkg::PC_SP0;
                        default: state_next = mer_pkg::SEQ_IDLE;
                    endcase
                end
            end
            default: state_next = mer_pkg::SEQ_IDLE;
        endcase
    end

    assign busy = (state_reg == mer_pkg::SEQ_RUN);

endmodule

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// Top level of the two-region midpoint ellipse rasterizer.
// Every transfer is taken in a cycle where the sequencer is idle; the sequencer
// then runs its microcode with s_tready low. A start transfer (tuser 0) loads
// centre and semi-axes and runs the words ST0 to ST4 to set up the squares and
// the region-1 decision; it returns nothing. Each step transfer (tuser 1)
// returns one point mirrored into four quadrants and runs the words SP0 and
// SP1: the first emits and advances x, y and the running products ry^2*x and
// rx^2*y, the second adds up the decision. The step on which the curve enters
// region 2 also runs SW0 to SW2, as the shared multiplier forms the new
// decision in two passes, one more word adds it up and the emitting word then
// runs again. The sequencer runs one item at a time, so no transfer is taken
// before the last one is through, and a step waits while the output register
// still holds an untaken point. The point where y reaches zero carries
// m_tlast; steps after it, or before any start, are taken and dropped.
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11,
    localparam int OUT_W      = COORD_BITS + 2,
    localparam int S_TDATA_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((8 * OUT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // center_x, center_y, radius_x, radius_y
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // px_right, px_left, py_lower, py_upper, q1_x, q1_y, q3_x, q3_y
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int R     = RADIUS_BITS;
    localparam int C     = COORD_BITS;
    localparam int OFF_W = R + 1;
    localparam int SQ_W  = 2 * R;
    localparam int PQ_W  = 3 * R + 1;
    localparam int MA_W  = 3 * R + 3;
    localparam int MB_W  = R + 3;
    localparam int DEC_W = 4 * R + 4;

    logic [C-1:0] in_cx, in_cy;
    logic [R-1:0] in_rx, in_ry;
    logic         accept, launch, busy;

    mer_pkg::mer_pc_t    launch_pc;
    mer_pkg::mer_cw_t    cw;
    mer_pkg::mer_flags_t flags;

    logic [C-1:0]             ccol_reg, ccol_next, crow_reg, crow_next;
    logic [R-1:0]             rx_reg, rx_next, ry_reg, ry_next;
    logic [SQ_W-1:0]          sx_reg, sx_next, sy_reg, sy_next;
    logic [PQ_W-1:0]          p_reg, p_next, q_reg, q_next;
    logic [OFF_W-1:0]         x_reg, x_next, y_reg, y_next;
    logic signed [MA_W-1:0]   tmp_reg, tmp_next;
    logic signed [DEC_W-1:0]  sxsy_reg, sxsy_next;
    logic signed [DEC_W-1:0]  d_reg, d_next;
    logic signed [DEC_W-1:0]  prod_reg, prod_next;
    logic                     mvx_reg, mvx_next, mvy_reg, mvy_next;
    logic                     r2_reg, r2_next, active_reg, active_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_last_reg, out_last_next;
    logic [OUT_W-1:0]         xr_reg, xr_next, xl_reg, xl_next;
    logic [OUT_W-1:0]         yl_reg, yl_next, yu_reg, yu_next;

    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [MA_W+MB_W-1:0] mul_p;
    logic signed [DEC_W-1:0]     sx_d, sy_d, p_d, q_d, d_step;
    logic                        take_sw, at_last, out_free, hold, emit_fire, d_neg;

    assign in_cx = s_tdata[C-1:0];
    assign in_cy = s_tdata[2*C-1:C];
    assign in_rx = s_tdata[2*C+R-1:2*C];
    assign in_ry = s_tdata[2*C+2*R-1:2*C+R];

    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign launch    = accept && (s_tuser == mer_pkg::OP_START || active_reg);
    assign launch_pc = (s_tuser == mer_pkg::OP_START) ? mer_pkg::PC_ST0 : mer_pkg::PC_SP0;

    assign take_sw   = cw.emit && !r2_reg && (p_reg > q_reg);
    assign at_last   = (y_reg == '0);
    assign out_free  = !out_valid_reg || m_tready;
    assign hold      = cw.emit && !take_sw && !out_free;
    assign emit_fire = cw.emit && !take_sw && out_free;

    assign flags = '{take_sw: take_sw, last: at_last, hold: hold};

    mer_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .launch    (launch),
        .launch_pc (launch_pc),
        .flags     (flags),
        .cw        (cw),
        .busy      (busy)
    );

    // shared multiplier, result registered in prod_reg
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cw.mul_sel)
            mer_pkg::MUL_RX_RX: begin
                mul_a = signed'(MA_W'(rx_reg));
                mul_b = signed'(MB_W'(rx_reg));
            end
            mer_pkg::MUL_RY_RY: begin
                mul_a = signed'(MA_W'(ry_reg));
                mul_b = signed'(MB_W'(ry_reg));
            end
            mer_pkg::MUL_SX_RY: begin
                mul_a = signed'(MA_W'(sx_reg));
                mul_b = signed'(MB_W'(ry_reg));
            end
            mer_pkg::MUL_PR_RY: begin
                mul_a = signed'(prod_reg[MA_W-1:0]);
                mul_b = signed'(MB_W'(ry_reg));
            end
            mer_pkg::MUL_P_X1: begin
                mul_a = signed'(MA_W'(p_reg));
                mul_b = signed'(MB_W'(x_reg) + MB_W'(1));
            end
            mer_pkg::MUL_TMP_Y1: begin
                mul_a = tmp_reg;
                mul_b = signed'(MB_W'(y_reg) - MB_W'(1));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign sx_d  = signed'(DEC_W'(sx_reg));
    assign sy_d  = signed'(DEC_W'(sy_reg));
    assign p_d   = signed'(DEC_W'(p_reg));
    assign q_d   = signed'(DEC_W'(q_reg));
    assign d_neg = d_reg[DEC_W-1];

    assign d_step = d_reg
                  + (mvx_reg ? (p_d <<< 3) : DEC_W'(0))
                  - (mvy_reg ? (q_d <<< 3) : DEC_W'(0))
                  + (r2_reg ? (sx_d <<< 2) : (sy_d <<< 2));

    always_comb begin
        ccol_next   = ccol_reg;
        crow_next   = crow_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        tmp_next    = tmp_reg;
        sxsy_next   = sxsy_reg;
        d_next      = d_reg;
        prod_next   = prod_reg;
        mvx_next    = mvx_reg;
        mvy_next    = mvy_reg;
        r2_next     = r2_reg;
        active_next = active_reg;

        if (accept && s_tuser == mer_pkg::OP_START) begin
            ccol_next   = in_cx;
            crow_next   = in_cy;
            rx_next     = in_rx;
            ry_next     = in_ry;
            x_next      = '0;
            y_next      = OFF_W'(in_ry);
            p_next      = '0;
            r2_next     = 1'b0;
            active_next = 1'b1;
        end

        if (cw.mul_sel != mer_pkg::MUL_NONE) begin
            prod_next = signed'(mul_p[DEC_W-1:0]);
        end

        case (cw.wr_sel)
            mer_pkg::WR_SX:   sx_next   = prod_reg[SQ_W-1:0];
            mer_pkg::WR_SY:   sy_next   = prod_reg[SQ_W-1:0];
            mer_pkg::WR_Q:    q_next    = prod_reg[PQ_W-1:0];
            mer_pkg::WR_SXSY: sxsy_next = prod_reg;
            default: ;
        endcase

        if (cw.tmp_ld) begin
            tmp_next = signed'(MA_W'(q_reg)) - signed'(MA_W'(sx_reg));
        end
        if (cw.set_r2) begin
            r2_next = 1'b1;
        end

        if (emit_fire) begin
            if (at_last) begin
                active_next = 1'b0;
            end else if (!r2_reg) begin
                x_next   = x_reg + OFF_W'(1);
                p_next   = p_reg + PQ_W'(sy_reg);
                mvx_next = 1'b1;
                if (d_neg) begin
                    mvy_next = 1'b0;
                end else begin
                    y_next   = y_reg - OFF_W'(1);
                    q_next   = q_reg - PQ_W'(sx_reg);
                    mvy_next = 1'b1;
                end
            end else begin
                y_next   = y_reg - OFF_W'(1);
                q_next   = q_reg - PQ_W'(sx_reg);
                mvy_next = 1'b1;
                if (!d_neg && d_reg != '0) begin
                    mvx_next = 1'b0;
                end else begin
                    x_next   = x_reg + OFF_W'(1);
                    p_next   = p_reg + PQ_W'(sy_reg);
                    mvx_next = 1'b1;
                end
            end
        end

        case (cw.dec_op)
            mer_pkg::DEC_INIT: d_next = (sy_d <<< 2) - (q_d <<< 2) + sx_d;
            mer_pkg::DEC_STEP: d_next = d_step;
            mer_pkg::DEC_SW_A: d_next = (prod_reg <<< 2) + sy_d - (sxsy_reg <<< 2);
            mer_pkg::DEC_SW_B: d_next = d_reg + (prod_reg <<< 2);
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        xr_next        = xr_reg;
        xl_next        = xl_reg;
        yl_next        = yl_reg;
        yu_next        = yu_reg;
        if (emit_fire) begin
            out_valid_next = 1'b1;
            out_last_next  = at_last;
            xr_next        = OUT_W'(ccol_reg) + OUT_W'(x_reg);
            xl_next        = OUT_W'(ccol_reg) - OUT_W'(x_reg);
            yl_next        = OUT_W'(crow_reg) + OUT_W'(y_reg);
            yu_next        = OUT_W'(crow_reg) - OUT_W'(y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            r2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            r2_reg        <= r2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ccol_reg     <= ccol_next;
        crow_reg     <= crow_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        tmp_reg      <= tmp_next;
        sxsy_reg     <= sxsy_next;
        d_reg        <= d_next;
        prod_reg     <= prod_next;
        mvx_reg      <= mvx_next;
        mvy_reg      <= mvy_next;
        out_last_reg <= out_last_next;
        xr_reg       <= xr_next;
        xl_reg       <= xl_next;
        yl_reg       <= yl_next;
        yu_reg       <= yu_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_W'({yu_reg, xl_reg, yl_reg, xr_reg,
                                  yu_reg, yl_reg, xl_reg, xr_reg});

endmodule

// ===== rtl/mer_checker.sv =====
// Port-level checks of the ellipse rasterizer, bound to the top level.
`include "midpoint_ellipse_rasterizer_macros.svh"

module mer_checker #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11,
    localparam int OUT_W      = COORD_BITS + 2,
    localparam int M_TDATA_W  = ((8 * OUT_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    // op
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    // px_right, px_left, py_lower, py_upper, q1_x, q1_y, q3_x, q3_y
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic start_xfer;

    assign start_xfer = s_tvalid && s_tready && s_tuser == mer_pkg::OP_START;

    `MER_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid,
                     "result dropped while stalled")
    `MER_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata),
                     "result changed while stalled")
    `MER_ASSERT_NEXT(a_start_busy, start_xfer, !s_tready,
                     "input taken again straight after a start transfer")
    `MER_ASSERT_NEXT(a_start_silent, start_xfer && !(m_tvalid && !m_tready), !m_tvalid,
                     "start transfer produced a result")
    `MER_ASSERT_NOW(a_last_on_axis, m_tvalid && m_tlast,
                    m_tdata[3*OUT_W-1:2*OUT_W] == m_tdata[4*OUT_W-1:3*OUT_W],
                    "final point not on the centre row")

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
) u_mer_checker (.*);
